// ----- rtl/core/spr_pkg.sv -----
// Shared types, constants and geometry functions for the segment pair relation block.
package spr_pkg;

    // Port width of one coordinate and the number of bits actually used
    localparam int IN_W       = 16;
    localparam int COORD_BITS = 16;
    localparam int DIFF_W     = COORD_BITS + 1;
    localparam int PROD_W     = 2 * DIFF_W;
    localparam int CROSS_W    = PROD_W + 1;

    typedef logic signed [COORD_BITS-1:0] t_coord;
    typedef logic signed [DIFF_W-1:0]     t_diff;
    typedef logic signed [PROD_W-1:0]     t_prod;
    typedef logic signed [CROSS_W-1:0]    t_cross;

    // Relation codes on the result word
    typedef enum logic [1:0] {
        REL_NP_DISJOINT  = 2'd0,
        REL_NP_CROSS     = 2'd1,
        REL_PAR_DISJOINT = 2'd2,
        REL_PAR_OVERLAP  = 2'd3
    } t_relation;

    // One segment pair after truncation to COORD_BITS
    typedef struct packed {
        t_coord ax0;
        t_coord ay0;
        t_coord ax1;
        t_coord ay1;
        t_coord bx0;
        t_coord by0;
        t_coord bx1;
        t_coord by1;
    } t_seg_pair;

    // Exact difference of two coordinates
    function automatic t_diff f_diff(input t_coord a, input t_coord b);
        return t_diff'(a) - t_diff'(b);
    endfunction

    // u x v on exact differences
    function automatic t_cross f_cross(input t_diff ux, input t_diff uy,
                                       input t_diff vx, input t_diff vy);
        t_prod p0;
        t_prod p1;
        p0 = t_prod'(ux) * t_prod'(vy);
        p1 = t_prod'(uy) * t_prod'(vx);
        return t_cross'(p0) - t_cross'(p1);
    endfunction

    // (q - o) x (r - o)
    function automatic t_cross f_orient(input t_coord ox, input t_coord oy,
                                        input t_coord qx, input t_coord qy,
                                        input t_coord rx, input t_coord ry);
        return f_cross(f_diff(qx, ox), f_diff(qy, oy), f_diff(rx, ox), f_diff(ry, oy));
    endfunction

    // v lies between e0 and e1, ends included, either order
    function automatic logic f_between(input t_coord v, input t_coord e0, input t_coord e1);
        return ((v >= e0) && (v <= e1)) || ((v <= e0) && (v >= e1));
    endfunction

    // Point p on segment s-e: inside the bounding box and collinear
    function automatic logic f_on_seg(input t_coord px, input t_coord py,
                                      input t_coord sx, input t_coord sy,
                                      input t_coord ex, input t_coord ey);
        return f_between(px, sx, ex) && f_between(py, sy, ey)
            && (f_orient(sx, sy, ex, ey, px, py) == '0);
    endfunction

endpackage

// ----- rtl/core/segment_pair_relation.sv -----
// Top level: classifies a pair of line segments as crossing, disjoint or overlapping.
//
//  channel | direction | handshake           | words
//  --------+-----------+---------------------+------------------------------------
//  input   | in        | i_valid / o_ready   | eight signed coordinates, two segments
//  result  | out       | o_valid / i_ready   | o_relation, one per input word
//
// One word is taken every cycle while o_ready is high; it lands in the input register at
// acceptance and its result is computed combinationally from that register and
// written into the result register when the output side is not stalled. The orientation
// cross products and sign logic form a single combinational path between the two registers.
// Reset (i_rst_n low, synchronous) empties both stages; no payload is cleared.
// A stalled result holds in the result register while the input register still
// takes one more word; o_ready drops only when both stages are full and stalled.
module segment_pair_relation (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  logic                     i_valid,
    output logic                     o_ready,
    input  logic [spr_pkg::IN_W-1:0] i_a_start_x,
    input  logic [spr_pkg::IN_W-1:0] i_a_start_y,
    input  logic [spr_pkg::IN_W-1:0] i_a_end_x,
    input  logic [spr_pkg::IN_W-1:0] i_a_end_y,
    input  logic [spr_pkg::IN_W-1:0] i_b_start_x,
    input  logic [spr_pkg::IN_W-1:0] i_b_start_y,
    input  logic [spr_pkg::IN_W-1:0] i_b_end_x,
    input  logic [spr_pkg::IN_W-1:0] i_b_end_y,
    output logic                     o_valid,
    input  logic                     i_ready,
    output logic [1:0]               o_relation
);
    import spr_pkg::*;

    logic      r_v1;
    logic      r_v2;
    t_seg_pair r_in;
    t_seg_pair n_in;
    t_relation r_rel;
    t_relation n_rel;
    logic      adv2;

    t_cross    dir_cross;
    logic      dir_zero;
    logic      common;
    t_cross    o1, o2, o3, o4;
    logic      z1, z2, z3, z4;
    logic      straddle_a, straddle_b;

    // Pipeline flow control
    assign adv2    = !r_v2 || i_ready;
    assign o_ready = !r_v1 || adv2;
    assign o_valid = r_v2;
    assign o_relation = r_rel;

    // Keep only the low COORD_BITS of each coordinate
    always_comb begin
        n_in.ax0 = i_a_start_x[COORD_BITS-1:0];
        n_in.ay0 = i_a_start_y[COORD_BITS-1:0];
        n_in.ax1 = i_a_end_x[COORD_BITS-1:0];
        n_in.ay1 = i_a_end_y[COORD_BITS-1:0];
        n_in.bx0 = i_b_start_x[COORD_BITS-1:0];
        n_in.by0 = i_b_start_y[COORD_BITS-1:0];
        n_in.bx1 = i_b_end_x[COORD_BITS-1:0];
        n_in.by1 = i_b_end_y[COORD_BITS-1:0];
    end

    // Input stage
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
        end else if (o_ready) begin
            r_v1 <= i_valid;
        end
        if (i_valid && o_ready) begin
            r_in <= n_in;
        end
    end

    // Direction cross product decides parallel or not
    assign dir_cross = f_cross(f_diff(r_in.ax1, r_in.ax0), f_diff(r_in.ay1, r_in.ay0),
                               f_diff(r_in.bx1, r_in.bx0), f_diff(r_in.by1, r_in.by0));
    assign dir_zero  = (dir_cross == '0);

    // Parallel case: any endpoint lying on the other segment
    assign common = f_on_seg(r_in.bx0, r_in.by0, r_in.ax0, r_in.ay0, r_in.ax1, r_in.ay1)
                 || f_on_seg(r_in.bx1, r_in.by1, r_in.ax0, r_in.ay0, r_in.ax1, r_in.ay1)
                 || f_on_seg(r_in.ax0, r_in.ay0, r_in.bx0, r_in.by0, r_in.bx1, r_in.by1)
                 || f_on_seg(r_in.ax1, r_in.ay1, r_in.bx0, r_in.by0, r_in.bx1, r_in.by1);

    // Nonparallel case: orientation of each endpoint against the other line
    assign o1 = f_orient(r_in.bx0, r_in.by0, r_in.bx1, r_in.by1, r_in.ax0, r_in.ay0);
    assign o2 = f_orient(r_in.bx0, r_in.by0, r_in.bx1, r_in.by1, r_in.ax1, r_in.ay1);
    assign o3 = f_orient(r_in.ax0, r_in.ay0, r_in.ax1, r_in.ay1, r_in.bx0, r_in.by0);
    assign o4 = f_orient(r_in.ax0, r_in.ay0, r_in.ax1, r_in.ay1, r_in.bx1, r_in.by1);
    assign z1 = (o1 == '0);
    assign z2 = (o2 == '0);
    assign z3 = (o3 == '0);
    assign z4 = (o4 == '0);

    // Sign product <= 0: a zero, or opposite signs
    assign straddle_a = z1 || z2 || (o1[CROSS_W-1] != o2[CROSS_W-1]);
    assign straddle_b = z3 || z4 || (o3[CROSS_W-1] != o4[CROSS_W-1]);

    // Relation select
    always_comb begin
        if (dir_zero) begin
            n_rel = common ? REL_PAR_OVERLAP : REL_PAR_DISJOINT;
        end else begin
            n_rel = (straddle_a && straddle_b) ? REL_NP_CROSS : REL_NP_DISJOINT;
        end
    end

    // Result stage
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v2 <= 1'b0;
        end else if (adv2) begin
            r_v2 <= r_v1;
        end
        if (adv2 && r_v1) begin
            r_rel <= n_rel;
        end
    end

    // Reset empties both stages
    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !r_v1 && !r_v2)
        else $error("pipeline not empty after reset");

    // A word in the input stage moves on whenever the result stage can take it
    a_advance: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_v1 && adv2 |=> r_v2)
        else $error("word lost between stages");

    // Parallel codes exactly when the direction cross product is zero
    a_parallel: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_v1 && adv2 |=> (r_rel[1] == $past(dir_zero)))
        else $error("parallel flag disagrees with direction cross product");

endmodule
